// File: rtl/two_bit_weight_dequantizer_defines.svh
// Assertion macros for the two-bit weight dequantizer.
`ifndef TWO_BIT_WEIGHT_DEQUANTIZER_DEFINES_SVH
`define TWO_BIT_WEIGHT_DEQUANTIZER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define TBWD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define TBWD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: rtl/tbwd_pkg.sv
// Shared constants, types and functions of the two-bit weight dequantizer.
package tbwd_pkg;
    localparam int BlockWeights = 256;
    localparam int ScaleBytes = 4;
    localparam int PackedBytes = BlockWeights / 4;
    localparam int PosW = $clog2(ScaleBytes + PackedBytes + 1);
    localparam logic [PosW-1:0] LastPos = PosW'(ScaleBytes + PackedBytes - 1);
    localparam logic [PosW-1:0] FirstCodePos = PosW'(ScaleBytes);
    localparam logic [31:0] SignBit = 32'h8000_0000;
    localparam logic [31:0] QuietBit = 32'h0040_0000;
    localparam logic [31:0] OneBits = 32'h3F80_0000;
    // 0.33333333f = 0x3EAAAAAB: significand 0xAAAAAB, exponent -2
    localparam logic [23:0] ThirdMant = 24'hAAAAAB;
    localparam logic [1:0] CodeNegOne = 2'd0;
    localparam logic [1:0] CodeNegThird = 2'd1;
    localparam logic [1:0] CodePosThird = 2'd2;
    localparam logic [1:0] CodePosOne = 2'd3;

    typedef struct packed {
        logic [7:0] codes;
        logic [31:0] scale;
        logic [7:0] index;
        logic last;
    } item_t;

    // Stage-1 product of one lane, before normalization and rounding.
    typedef struct packed {
        logic [1:0] code;
        logic [31:0] scale;
        logic [47:0] prod;
        logic signed [10:0] exp;
    } prod_t;
endpackage

// File: rtl/tbwd_byte_if.sv
// Byte input channel.
interface tbwd_byte_if;
    logic valid;
    logic ready;
    logic [7:0] byte_in;
    modport source (output valid, output byte_in, input ready);
    modport sink (input valid, input byte_in, output ready);
endinterface

// File: rtl/tbwd_weight_if.sv
// Weight result channel.
interface tbwd_weight_if;
    logic valid;
    logic ready;
    logic [31:0] lane0_value;
    logic [31:0] lane1_value;
    logic [31:0] lane2_value;
    logic [31:0] lane3_value;
    logic [7:0] first_weight_index;
    logic block_end;
    modport source (output valid, output lane0_value, output lane1_value,
                    output lane2_value, output lane3_value,
                    output first_weight_index, output block_end, input ready);
    modport sink (input valid, input lane0_value, input lane1_value,
                  input lane2_value, input lane3_value,
                  input first_weight_index, input block_end, output ready);
endinterface

// File: rtl/two_bit_weight_dequantizer.sv
// Code word path: it1_reg, p2_reg, lanes3_reg; scale words give no result.
// Throughput: one word per cycle unless stalled; four lanes with two-stage multiply/round.
// Output register and skid-free stall: the whole pipe advances when the result slot frees.
// Reset: asynchronous, active low; clears byte position, scale and valid bits.
`include "two_bit_weight_dequantizer_defines.svh"
module two_bit_weight_dequantizer (
    input  logic clk,
    input  logic rst_n,
    tbwd_byte_if.sink in_ch,
    tbwd_weight_if.source out_ch
);
    logic [tbwd_pkg::PosW-1:0] pos_reg, pos_next;
    logic [31:0] scale_reg, scale_next;
    logic v1_reg, v2_reg, v3_reg;
    tbwd_pkg::item_t it1_reg;
    tbwd_pkg::prod_t p2_reg [4];
    logic [7:0] idx2_reg;
    logic last2_reg;
    logic [31:0] lanes3_reg [4];
    logic [7:0] idx3_reg;
    logic last3_reg;
    logic adv;
    logic acc;
    tbwd_pkg::prod_t pm [4];
    logic [31:0] rv [4];
    logic [31:0] asm_scale;

    assign adv = !v3_reg || out_ch.ready;
    assign in_ch.ready = adv;
    assign acc = in_ch.valid && adv;

    always_comb
    begin
        pos_next = pos_reg;
        scale_next = scale_reg;
        asm_scale = scale_reg;
        case (pos_reg)
            tbwd_pkg::PosW'(0): asm_scale[7:0] = in_ch.byte_in;
            tbwd_pkg::PosW'(1): asm_scale[15:8] = in_ch.byte_in;
            tbwd_pkg::PosW'(2): asm_scale[23:16] = in_ch.byte_in;
            tbwd_pkg::PosW'(3): asm_scale[31:24] = in_ch.byte_in;
            default: asm_scale = scale_reg;
        endcase
        if (acc)
        begin
            if (pos_reg < tbwd_pkg::FirstCodePos)
            begin
                scale_next = asm_scale;
                if (pos_reg == tbwd_pkg::FirstCodePos - 1'b1 && asm_scale[30:0] == 31'd0)
                begin
                    scale_next = tbwd_pkg::OneBits;
                end
            end
            pos_next = (pos_reg == tbwd_pkg::LastPos) ? '0 : pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            scale_reg <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            scale_reg <= scale_next;
            if (adv)
            begin
                v1_reg <= acc && (pos_reg >= tbwd_pkg::FirstCodePos);
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it1_reg.codes <= in_ch.byte_in;
            it1_reg.scale <= scale_reg;
            it1_reg.index <= 8'({pos_reg - tbwd_pkg::FirstCodePos, 2'b00});
            it1_reg.last <= (pos_reg == tbwd_pkg::LastPos);
            p2_reg <= pm;
            idx2_reg <= it1_reg.index;
            last2_reg <= it1_reg.last;
            lanes3_reg <= rv;
            idx3_reg <= idx2_reg;
            last3_reg <= last2_reg;
        end
    end

    for (genvar l = 0; l < 4; l++)
    begin : g_lane
        tbwd_lane_mul u_mul (
            .code(it1_reg.codes[2*l +: 2]),
            .scale(it1_reg.scale),
            .prod(pm[l])
        );
        tbwd_lane_round u_rnd (
            .prod(p2_reg[l]),
            .value(rv[l])
        );
    end

    assign out_ch.valid = v3_reg;
    assign out_ch.lane0_value = lanes3_reg[0];
    assign out_ch.lane1_value = lanes3_reg[1];
    assign out_ch.lane2_value = lanes3_reg[2];
    assign out_ch.lane3_value = lanes3_reg[3];
    assign out_ch.first_weight_index = idx3_reg;
    assign out_ch.block_end = last3_reg;

    `TBWD_ASSERT_NEXT(a_pos_wrap, clk, rst_n, acc && pos_reg == tbwd_pkg::LastPos, pos_reg == '0)
    `TBWD_ASSERT_NEXT(a_scale_nonzero, clk, rst_n, acc && pos_reg == tbwd_pkg::FirstCodePos - 1'b1, scale_reg[30:0] != 31'd0)
    `TBWD_ASSERT_NEXT(a_stall_hold, clk, rst_n, v3_reg && !out_ch.ready, v3_reg && $stable(idx3_reg))
    `TBWD_ASSERT_IMP(a_idx_aligned, clk, rst_n, v3_reg, idx3_reg[1:0] == 2'b00)
endmodule

// File: rtl/tbwd_lane_mul.sv
// One lane: multiplier stage for scale times one third; the code is passed on.
module tbwd_lane_mul (
    input  logic [1:0] code,
    input  logic [31:0] scale,
    output tbwd_pkg::prod_t prod
);
    logic [7:0] e;
    logic [23:0] m;
    always_comb
    begin
        e = scale[30:23];
        m = (e == 8'd0) ? {1'b0, scale[22:0]} : {1'b1, scale[22:0]};
        prod.code = code;
        prod.scale = scale;
        prod.prod = m * tbwd_pkg::ThirdMant;
        // value = prod * 2^(exp-175); real exponent of a normal scale is e-127, third is -2-23
        prod.exp = (e == 8'd0) ? 11'sd1 : $signed({3'b000, e});
    end
endmodule

// File: rtl/tbwd_lane_round.sv
// One lane: normalize, round to nearest even, and handle special codes.
module tbwd_lane_round (
    input  tbwd_pkg::prod_t prod,
    output logic [31:0] value
);
    logic sign;
    logic [5:0] lz;
    logic [47:0] norm;
    logic signed [11:0] ex;
    logic [5:0] rsh;
    logic [48:0] shv;
    logic sticky;
    logic [24:0] mr;
    logic [23:0] keep;
    logic g;
    logic [8:0] eout;
    logic [31:0] mulv;
    logic nan;
    integer i;

    always_comb
    begin
        sign = prod.scale[31] ^ (prod.code == tbwd_pkg::CodeNegThird);
        lz = 6'd0;
        for (i = 0; i < 48; i++)
        begin
            if (prod.prod[i])
            begin
                lz = 6'(47 - i);
            end
        end
        norm = prod.prod << lz;
        // biased exponent of norm[47] as leading bit: exp - 1 - lz (third = 2^-2 * 1.333 ... ~ 2^-1 mantissa form)
        ex = 12'(prod.exp) - 12'sd1 - $signed({6'd0, lz});
        if (ex >= 12'sd1)
        begin
            rsh = 6'd0;
        end
        else if (ex < -12'sd30)
        begin
            rsh = 6'd31;
        end
        else
        begin
            rsh = 6'(12'sd1 - ex);
        end
        shv = {norm, 1'b0} >> rsh;
        sticky = |(({norm, 1'b0}) & ~({49{1'b1}} << rsh)) | (|shv[22:0]);
        keep = shv[48:25];
        g = shv[24];
        sticky = sticky | (|shv[23:0] & ~shv[24]) | (|shv[23:0]);
        sticky = (|({norm, 1'b0} & ~({49{1'b1}} << rsh))) | (|shv[23:0]);
        mr = {1'b0, keep} + 25'(g & (sticky | keep[0]));
        if (rsh != 6'd0)
        begin
            eout = {8'd0, mr[23]};
        end
        else
        begin
            eout = 9'(ex[8:0]) + 9'(mr[24]);
        end
        if (mr[24])
        begin
            mulv = {sign, eout[7:0], mr[23:1]};
        end
        else
        begin
            mulv = {sign, eout[7:0], mr[22:0]};
        end
        if (prod.prod == 48'd0)
        begin
            mulv = {sign, 31'd0};
        end
        if (prod.scale[30:23] == 8'hFF)
        begin
            mulv = {sign, 8'hFF, 23'd0};
        end
        nan = (prod.scale[30:23] == 8'hFF) && (prod.scale[22:0] != 23'd0);
        if (nan)
        begin
            mulv = {sign, prod.scale[30:0] | tbwd_pkg::QuietBit[30:0]};
        end
        case (prod.code)
            tbwd_pkg::CodeNegOne: value = prod.scale ^ tbwd_pkg::SignBit;
            tbwd_pkg::CodePosOne: value = prod.scale;
            default: value = mulv;
        endcase
    end
endmodule

// File: verif/tbwd_weight_checker.sv
// Checker for the two-bit weight dequantizer: predicts result words and compares them.
`timescale 1ns / 1ps
module tbwd_weight_checker (
    input  logic clk,
    input  logic rst_n,
    tbwd_byte_if in_ch,
    tbwd_weight_if out_ch,
    output int fail_count,
    output int pending
);
    typedef struct {
        logic [31:0] lane [4];
        logic [7:0] index;
        logic last;
    } weight_word_t;

    weight_word_t want_q[$];
    int byte_pos;
    logic [31:0] scale_word;

    assign pending = want_q.size();

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    // RNE single multiply of a non-NaN value by 0.33333333f, subnormals kept
    function automatic logic [31:0] third_product(logic [31:0] s, logic neg);
        logic sign;
        int e;
        int er;
        int sh;
        logic [23:0] m;
        logic [47:0] p;
        logic sticky;
        logic [24:0] q;
        logic [23:0] rem;
        logic [31:0] bits;
        sign = s[31] ^ neg;
        if (s[30:23] == 8'hFF)
            return {sign, 8'hFF, 23'd0};
        if (s[30:0] == 31'd0)
            return {sign, 31'd0};
        e = s[30:23];
        m = {1'b1, s[22:0]};
        if (e == 0)
        begin
            e = 1;
            m = {1'b0, s[22:0]};
            while (!m[23])
            begin
                m = m << 1;
                e--;
            end
        end
        p = 48'(m) * 48'(tbwd_pkg::ThirdMant);
        er = e + 125 - 127;
        if (p[47])
            er++;
        else
            p = p << 1;
        if (er >= 255)
            return {sign, 8'hFF, 23'd0};
        sticky = 1'b0;
        if (er < 1)
        begin
            sh = 1 - er;
            er = 1;
            if (sh >= 48)
            begin
                sticky = |p;
                p = '0;
            end
            else
            begin
                sticky = |(p & ((48'd1 << sh) - 48'd1));
                p = p >> sh;
            end
        end
        q = {1'b0, p[47:24]};
        rem = p[23:0];
        if (rem[23] && (rem[22:0] != 0 || sticky || q[0]))
            q = q + 25'd1;
        // carry out of the significand bumps the exponent field naturally
        bits = (32'(er - 1) << 23) + 32'(q);
        if (bits >= 32'h7F80_0000)
            return {sign, 8'hFF, 23'd0};
        return {sign, bits[30:0]};
    endfunction

    function automatic logic [31:0] weight_for_code(logic [1:0] code, logic [31:0] s);
        logic is_nan;
        is_nan = (s[30:23] == 8'hFF) && (s[22:0] != 0);
        case (code)
            tbwd_pkg::CodeNegOne:   return s ^ tbwd_pkg::SignBit;
            tbwd_pkg::CodePosOne:   return s;
            tbwd_pkg::CodeNegThird:
                return is_nan ? ((s | tbwd_pkg::QuietBit) ^ tbwd_pkg::SignBit)
                              : third_product(s, 1'b1);
            default: return is_nan ? (s | tbwd_pkg::QuietBit) : third_product(s, 1'b0);
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos <= 0;
            scale_word <= '0;
            want_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                if (byte_pos < tbwd_pkg::ScaleBytes)
                begin
                    logic [31:0] s;
                    s = scale_word;
                    s[8*byte_pos +: 8] = in_ch.byte_in;
                    if (byte_pos == tbwd_pkg::ScaleBytes - 1 && (s & ~tbwd_pkg::SignBit) == 0)
                        s = tbwd_pkg::OneBits;
                    scale_word <= s;
                    byte_pos <= byte_pos + 1;
                end
                else
                begin
                    weight_word_t w;
                    int idx;
                    idx = byte_pos - tbwd_pkg::ScaleBytes;
                    for (int k = 0; k < 4; k++)
                        w.lane[k] = weight_for_code(in_ch.byte_in[2*k +: 2], scale_word);
                    w.index = 8'(idx * 4);
                    w.last = (idx + 1 >= tbwd_pkg::PackedBytes);
                    byte_pos <= w.last ? 0 : byte_pos + 1;
                    want_q.push_back(w);
                end
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (want_q.size() == 0)
                begin
                    $display("%0t: result word with nothing expected", $realtime);
                    fail_count++;
                end
                else
                begin
                    weight_word_t w;
                    w = want_q.pop_front();
                    if (out_ch.lane0_value !== w.lane[0])
                        report_mismatch("lane0_value", out_ch.lane0_value, w.lane[0]);
                    if (out_ch.lane1_value !== w.lane[1])
                        report_mismatch("lane1_value", out_ch.lane1_value, w.lane[1]);
                    if (out_ch.lane2_value !== w.lane[2])
                        report_mismatch("lane2_value", out_ch.lane2_value, w.lane[2]);
                    if (out_ch.lane3_value !== w.lane[3])
                        report_mismatch("lane3_value", out_ch.lane3_value, w.lane[3]);
                    if (out_ch.first_weight_index !== w.index)
                        report_mismatch("first_weight_index",
                                        32'(out_ch.first_weight_index), 32'(w.index));
                    if (out_ch.block_end !== w.last)
                        report_mismatch("block_end", 32'(out_ch.block_end), 32'(w.last));
                end
            end
        end
    end
endmodule

// File: verif/tb_two_bit_weight_dequantizer.sv
// Testbench top for the two-bit weight dequantizer: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps
module tb_two_bit_weight_dequantizer;

    localparam int IdleLimit = 4000;
    localparam int HoldCycles = 300;

    logic clk;
    logic rst_n;
    int fail_count;
    int pending;
    int idle_cycles;
    bit gaps_on;
    bit hold_req;

    tbwd_byte_if in_ch();
    tbwd_weight_if out_ch();

    two_bit_weight_dequantizer dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source)
    );

    tbwd_weight_checker checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .fail_count(fail_count),
        .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit)
            begin
                $display("** two_bit_weight_dequantizer: FAILED **");
                $finish;
            end
        end
    end

    // receiver pacing; the loop's own edge wait closes each idle burst
    initial
    begin
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 7) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 16)) @(posedge clk);
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    task automatic send_byte(logic [7:0] b);
        if (gaps_on && $urandom_range(0, 11) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.byte_in <= b;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic send_block(logic [31:0] scale, bit pattern_codes);
        logic [7:0] pats [4];
        pats = '{8'h00, 8'hFF, 8'hE4, 8'h1B};
        for (int k = 0; k < tbwd_pkg::ScaleBytes; k++)
            send_byte(scale[8*k +: 8]);
        for (int k = 0; k < tbwd_pkg::PackedBytes; k++)
            send_byte((pattern_codes && k < 4) ? pats[k] : 8'($urandom));
    endtask

    function automatic logic [31:0] pick_scale();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0: return r;
            1: return {r[31], 8'h00, r[22:0]};
            2: return {r[31], 8'($urandom_range(1, 3)), r[22:0]};
            3: return {r[31], 8'($urandom_range(250, 254)), r[22:0]};
            4: return {r[31], 8'hFF, r[22:1], 1'b1};
            5: return {r[31], 31'h7F80_0000};
            6: return {r[31], 31'd0};
            default: return {r[31], 8'($urandom_range(100, 150)), r[22:0]};
        endcase
    endfunction

    initial
    begin
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.byte_in <= 8'h00;
        gaps_on = 1'b1;
        hold_req = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed scales: negative zero, signaling NaN, smallest subnormal, largest normal
        send_block(32'h8000_0000, 1'b1);
        send_block(32'h7F80_0001, 1'b1);
        send_block(32'h0000_0001, 1'b1);
        send_block(32'h7F7F_FFFF, 1'b1);

        // receiver holds off while bytes keep coming
        hold_req = 1'b1;
        send_block(pick_scale(), 1'b0);

        // sender pauses until the pipe drains
        in_ch.valid <= 1'b0;
        wait (pending == 0 && !hold_req);
        @(posedge clk);

        send_block(pick_scale(), 1'b0);

        gaps_on = 1'b0;
        send_block(pick_scale(), 1'b0);
        in_ch.valid <= 1'b0;

        wait (pending == 0);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("** two_bit_weight_dequantizer: PASSED **");
        else
            $display("** two_bit_weight_dequantizer: FAILED **");
        $finish;
    end
endmodule

// File: two_bit_weight_dequantizer.f
+incdir+rtl
rtl/tbwd_pkg.sv
rtl/tbwd_byte_if.sv
rtl/tbwd_weight_if.sv
rtl/tbwd_lane_mul.sv
rtl/tbwd_lane_round.sv
rtl/two_bit_weight_dequantizer.sv
verif/tbwd_weight_checker.sv
verif/tb_two_bit_weight_dequantizer.sv
